/* hdl/czp_pkg.sv */
// Shared constants, command and register codes, and lane control type for the filter core.
package czp_pkg;

    localparam int MAX_TAPS_DEF   = 15;
    localparam int MAX_WIDTH_DEF  = 512;
    localparam int COEFF_BITS_DEF = 16;

    localparam int MAX_HEIGHT = 4096;
    localparam int ROW_W      = 12;
    localparam int HGT_W      = 13;
    localparam int PIX_W      = 8;
    localparam int NUM_CH     = 3;

    localparam logic [1:0] CMD_COEFF = 2'd0;
    localparam logic [1:0] CMD_PIXEL = 2'd1;
    localparam logic [1:0] CMD_DRAIN = 2'd2;
    localparam logic [1:0] CMD_NOP   = 2'd3;

    localparam logic [1:0] CFG_FRAME_WIDTH  = 2'd0;
    localparam logic [1:0] CFG_FRAME_HEIGHT = 2'd1;
    localparam logic [1:0] CFG_KERNEL_SIZE  = 2'd2;
    localparam logic [1:0] CFG_NONE         = 2'd3;

    typedef struct packed {
        logic clear;
        logic en;
        logic mask;
    } lane_ctl_t;

endpackage

/* hdl/czp_lane.sv */
// One colour channel lane: registered product of coefficient and pixel, then accumulate.
module czp_lane #(
    parameter int COEFF_BITS = czp_pkg::COEFF_BITS_DEF,
    parameter int ACC_W      = 32
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  czp_pkg::lane_ctl_t            ctl,
    input  logic [COEFF_BITS-1:0]         coef,
    input  logic [czp_pkg::PIX_W-1:0]     pix,
    output logic [ACC_W-1:0]              acc
);

    localparam int PROD_W = COEFF_BITS + czp_pkg::PIX_W;

    logic [PROD_W-1:0] prod_reg;
    logic              pv_reg;
    logic [ACC_W-1:0]  acc_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pv_reg <= 1'b0;
        end
        else
        begin
            pv_reg <= ctl.en;
        end
    end

    // taps outside the frame contribute zero
    always_ff @(posedge clk)
    begin
        prod_reg <= ctl.mask ? coef * pix : '0;
        if (ctl.clear)
        begin
            acc_reg <= '0;
        end
        else if (pv_reg)
        begin
            acc_reg <= acc_reg + ACC_W'(prod_reg);
        end
    end

    assign acc = acc_reg;

endmodule

/* hdl/czp_merge.sv */
// Merge stage: rounds, scales and saturates the three lane sums into the output register.
module czp_merge #(
    parameter int COEFF_BITS = czp_pkg::COEFF_BITS_DEF,
    parameter int ACC_W      = 32
) (
    input  logic                                       clk,
    input  logic                                       rst_n,
    input  logic                                       load,
    input  logic                                       last,
    input  logic [czp_pkg::NUM_CH-1:0][ACC_W-1:0]      acc,
    input  logic                                       out_stall,
    output logic                                       out_valid,
    output logic [czp_pkg::PIX_W-1:0]                  chan0_out,
    output logic [czp_pkg::PIX_W-1:0]                  chan1_out,
    output logic [czp_pkg::PIX_W-1:0]                  chan2_out,
    output logic                                       frame_last
);

    localparam int SUM_W = ACC_W + 1;
    localparam logic [SUM_W-1:0] HALF = SUM_W'(1) << (COEFF_BITS - 1);

    logic [czp_pkg::NUM_CH-1:0][czp_pkg::PIX_W-1:0] sat;
    logic [czp_pkg::NUM_CH-1:0][czp_pkg::PIX_W-1:0] chan_reg;
    logic                                           last_reg;
    logic                                           valid_reg;

    always_comb
    begin
        logic [SUM_W-1:0] s;
        logic [SUM_W-1:0] v;
        for (int i = 0; i < czp_pkg::NUM_CH; i++)
        begin
            s = SUM_W'(acc[i]) + HALF;
            v = s >> COEFF_BITS;
            sat[i] = (v > SUM_W'(255)) ? 8'hFF : v[czp_pkg::PIX_W-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (load)
        begin
            valid_reg <= 1'b1;
        end
        else if (!out_stall)
        begin
            valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            chan_reg <= sat;
            last_reg <= last;
        end
    end

    assign out_valid  = valid_reg;
    assign chan0_out  = chan_reg[0];
    assign chan1_out  = chan_reg[1];
    assign chan2_out  = chan_reg[2];
    assign frame_last = last_reg;

endmodule

/* hdl/zero_padded_2d_convolution_rgb_core.sv */
// Top level of the zero-padded KxK filter over a three-channel raster stream.
//
// Words arrive in raster order on the input channel: command 0 loads one coefficient,
// 1 feeds a pixel, 2 asks for one pending output once the frame's pixels are in.
// Each output pixel is the coefficient-weighted sum of its KxK neighbourhood, pixels
// outside the frame read as zero; the sum is rounded half up, shifted down by
// COEFF_BITS and clamped to 0..255, one 8-bit value per channel, with frame_last on
// the frame's final pixel. A pixel or drain word that yields an output runs the tap loop,
// which walks the window one tap per cycle through the single read port of the line
// store, with the three channel lanes working in parallel on each tap. The finished
// word sits in an output register, so the next input word is taken while it waits,
// unless a second result is ready before the first is taken. Configuration writes
// restart the frame; the coefficient table resets to zero.
module zero_padded_2d_convolution_rgb_core #(
    parameter int MAX_TAPS   = czp_pkg::MAX_TAPS_DEF,
    parameter int MAX_WIDTH  = czp_pkg::MAX_WIDTH_DEF,
    parameter int COEFF_BITS = czp_pkg::COEFF_BITS_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    // input words
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [1:0]  command,
    input  logic [3:0]  tap_h,
    input  logic [3:0]  tap_v,
    input  logic [15:0] coeff,
    input  logic [7:0]  chan0_in,
    input  logic [7:0]  chan1_in,
    input  logic [7:0]  chan2_in,
    // result words
    output logic        out_valid,
    input  logic        out_stall,
    output logic [7:0]  chan0_out,
    output logic [7:0]  chan1_out,
    output logic [7:0]  chan2_out,
    output logic        frame_last,
    // configuration
    input  logic        wr_en,
    input  logic [1:0]  wr_index,
    input  logic [12:0] wr_data
);

    localparam int LINE_ROWS = MAX_TAPS + 2;
    localparam int RW        = $clog2(LINE_ROWS);
    localparam int COL_W     = $clog2(MAX_WIDTH);
    localparam int EW        = $clog2(MAX_WIDTH + 1);
    localparam int KW        = $clog2(MAX_TAPS + 1);
    localparam int TI        = (MAX_TAPS > 1) ? $clog2(MAX_TAPS) : 1;
    localparam int TAP_XW    = (TI > 4) ? TI : 4;
    localparam int CX_W      = (COEFF_BITS > 16) ? COEFF_BITS : 16;
    localparam int ROW_W     = czp_pkg::ROW_W;
    localparam int HW        = czp_pkg::HGT_W;
    localparam int RSW       = ROW_W + 2;
    localparam int CSW       = ((COL_W > TI) ? COL_W : TI) + 2;
    localparam int ACC_W     = COEFF_BITS + czp_pkg::PIX_W + $clog2(MAX_TAPS * MAX_TAPS);
    localparam int NCH       = czp_pkg::NUM_CH;

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_CHECK = 3'd1;
    localparam logic [2:0] S_SWEEP = 3'd2;
    localparam logic [2:0] S_FLUSH = 3'd3;
    localparam logic [2:0] S_EMIT  = 3'd4;

    localparam logic [1:0] CMD_COEFF_C = czp_pkg::CMD_COEFF;
    localparam logic [1:0] CMD_PIXEL_C = czp_pkg::CMD_PIXEL;
    localparam logic [1:0] CMD_DRAIN_C = czp_pkg::CMD_DRAIN;
    localparam logic [1:0] CFG_W_C     = czp_pkg::CFG_FRAME_WIDTH;
    localparam logic [1:0] CFG_H_C     = czp_pkg::CFG_FRAME_HEIGHT;
    localparam logic [1:0] CFG_K_C     = czp_pkg::CFG_KERNEL_SIZE;

    // control registers
    logic [2:0]            state_reg, state_next;
    logic [9:0]            fw_reg, fw_next;
    logic [12:0]           fh_reg, fh_next;
    logic [3:0]            ks_reg, ks_next;
    logic [COL_W-1:0]      in_col_reg, in_col_next;
    logic [ROW_W-1:0]      in_row_reg, in_row_next;
    logic [RW-1:0]         in_ring_reg, in_ring_next;
    logic                  in_done_reg, in_done_next;
    logic [COL_W-1:0]      out_col_reg, out_col_next;
    logic [ROW_W-1:0]      out_row_reg, out_row_next;
    logic [RW-1:0]         out_ring_reg, out_ring_next;
    logic [TI-1:0]         tv_reg, tv_next;
    logic [TI-1:0]         th_reg, th_next;
    logic signed [RSW-1:0] r_reg, r_next;
    logic signed [CSW-1:0] c_reg, c_next;
    logic signed [CSW-1:0] c0_reg, c0_next;
    logic [RW-1:0]         ring_reg, ring_next;
    logic                  flush_reg, flush_next;
    logic                  s1_valid_reg;
    logic                  s1_mask_reg;
    logic [MAX_TAPS-1:0][MAX_TAPS-1:0] cvalid_reg;

    // effective frame geometry
    logic [EW-1:0]         w_eff;
    logic [HW-1:0]         h_eff;
    logic [KW-1:0]         k_eff;
    logic [KW-1:0]         khalf;
    logic [KW-1:0]         below;

    logic                  ready;
    logic                  in_frame;
    logic                  issue;
    logic                  px_we;
    logic                  cf_we;
    logic                  lane_clear;
    logic                  load;
    logic                  last;
    logic [COL_W-1:0]      rd_col;

    logic [TAP_XW-1:0]     th_x, tv_x;
    logic [CX_W-1:0]       coeff_x;
    logic [COEFF_BITS-1:0] coef_wr;

    // memories and read data
    logic [NCH*8-1:0]      line_mem [LINE_ROWS][MAX_WIDTH];
    logic [COEFF_BITS-1:0] coef_mem [MAX_TAPS][MAX_TAPS];
    logic [NCH*8-1:0]      pix_q;
    logic [COEFF_BITS-1:0] coef_q;
    logic                  cval_q;
    logic [COEFF_BITS-1:0] coef_use;
    logic [NCH-1:0][ACC_W-1:0] acc;
    czp_pkg::lane_ctl_t    lane_ctl;

    // clamp the registers to their legal ranges
    always_comb
    begin
        if (fw_reg == '0)
            w_eff = EW'(1);
        else if (32'(fw_reg) > MAX_WIDTH)
            w_eff = EW'(MAX_WIDTH);
        else
            w_eff = EW'(fw_reg);

        if (fh_reg == '0)
            h_eff = HW'(1);
        else if (32'(fh_reg) > czp_pkg::MAX_HEIGHT)
            h_eff = HW'(czp_pkg::MAX_HEIGHT);
        else
            h_eff = HW'(fh_reg);

        if (ks_reg == '0)
            k_eff = KW'(1);
        else if (32'(ks_reg) > MAX_TAPS)
            k_eff = KW'(MAX_TAPS);
        else
            k_eff = KW'(ks_reg);

        khalf = k_eff >> 1;
        below = k_eff - KW'(1) - khalf;
    end

    // window of the pending output complete?
    always_comb
    begin
        logic [HW:0]    lr_full;
        logic [HW-1:0]  hm1;
        logic [HW-1:0]  lr;
        logic [CSW-1:0] lc_full;
        logic [CSW-1:0] wm1;
        logic [CSW-1:0] lc;
        lr_full = (HW+1)'(out_row_reg) + (HW+1)'(below);
        hm1     = h_eff - HW'(1);
        lr      = (lr_full > (HW+1)'(hm1)) ? hm1 : lr_full[HW-1:0];
        lc_full = CSW'(out_col_reg) + CSW'(below);
        wm1     = CSW'(w_eff) - CSW'(1);
        lc      = (lc_full > wm1) ? wm1 : lc_full;
        ready   = in_done_reg || (HW'(in_row_reg) > lr)
               || ((HW'(in_row_reg) == lr) && (CSW'(in_col_reg) > lc));
    end

    assign in_frame = (r_reg >= 0) && (r_reg < $signed(RSW'(h_eff)))
                   && (c_reg >= 0) && (c_reg < $signed(CSW'(w_eff)));
    assign rd_col   = in_frame ? c_reg[COL_W-1:0] : '0;

    assign th_x    = TAP_XW'(tap_h);
    assign tv_x    = TAP_XW'(tap_v);
    assign coeff_x = CX_W'(coeff);
    assign coef_wr = coeff_x[COEFF_BITS-1:0];

    assign last = (HW'(out_row_reg) == h_eff - HW'(1))
               && (EW'(out_col_reg) == w_eff - EW'(1));

    always_comb
    begin
        state_next    = state_reg;
        fw_next       = fw_reg;
        fh_next       = fh_reg;
        ks_next       = ks_reg;
        in_col_next   = in_col_reg;
        in_row_next   = in_row_reg;
        in_ring_next  = in_ring_reg;
        in_done_next  = in_done_reg;
        out_col_next  = out_col_reg;
        out_row_next  = out_row_reg;
        out_ring_next = out_ring_reg;
        tv_next       = tv_reg;
        th_next       = th_reg;
        r_next        = r_reg;
        c_next        = c_reg;
        c0_next       = c0_reg;
        ring_next     = ring_reg;
        flush_next    = flush_reg;
        issue         = 1'b0;
        px_we         = 1'b0;
        cf_we         = 1'b0;
        lane_clear    = 1'b0;
        load          = 1'b0;

        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    case (command)
                        CMD_COEFF_C:
                        begin
                            cf_we = (32'(tap_h) < MAX_TAPS) && (32'(tap_v) < MAX_TAPS);
                        end
                        CMD_PIXEL_C:
                        begin
                            if (!in_done_reg)
                            begin
                                px_we = 1'b1;
                                if (EW'(in_col_reg) + EW'(1) >= w_eff)
                                begin
                                    in_col_next = '0;
                                    if (HW'(in_row_reg) + HW'(1) >= h_eff)
                                    begin
                                        in_row_next  = '0;
                                        in_ring_next = '0;
                                        in_done_next = 1'b1;
                                    end
                                    else
                                    begin
                                        in_row_next  = in_row_reg + ROW_W'(1);
                                        in_ring_next = (32'(in_ring_reg) == LINE_ROWS - 1)
                                                     ? '0 : in_ring_reg + RW'(1);
                                    end
                                end
                                else
                                begin
                                    in_col_next = in_col_reg + COL_W'(1);
                                end
                            end
                            state_next = S_CHECK;
                        end
                        CMD_DRAIN_C:
                        begin
                            state_next = S_CHECK;
                        end
                        default:
                        begin
                        end
                    endcase
                end
            end
            S_CHECK:
            begin
                if (ready)
                begin
                    lane_clear = 1'b1;
                    tv_next    = '0;
                    th_next    = '0;
                    r_next     = RSW'(out_row_reg) - RSW'(khalf);
                    c_next     = CSW'(out_col_reg) - CSW'(khalf);
                    c0_next    = CSW'(out_col_reg) - CSW'(khalf);
                    if ((RW+1)'(out_ring_reg) >= (RW+1)'(khalf))
                        ring_next = RW'((RW+1)'(out_ring_reg) - (RW+1)'(khalf));
                    else
                        ring_next = RW'((RW+1)'(out_ring_reg) + (RW+1)'(LINE_ROWS)
                                        - (RW+1)'(khalf));
                    state_next = S_SWEEP;
                end
                else
                begin
                    state_next = S_IDLE;
                end
            end
            S_SWEEP:
            begin
                issue = 1'b1;
                if (KW'(th_reg) == k_eff - KW'(1))
                begin
                    th_next   = '0;
                    c_next    = c0_reg;
                    tv_next   = tv_reg + TI'(1);
                    r_next    = r_reg + RSW'(1);
                    ring_next = (32'(ring_reg) == LINE_ROWS - 1) ? '0 : ring_reg + RW'(1);
                    if (KW'(tv_reg) == k_eff - KW'(1))
                    begin
                        flush_next = 1'b0;
                        state_next = S_FLUSH;
                    end
                end
                else
                begin
                    th_next = th_reg + TI'(1);
                    c_next  = c_reg + CSW'(1);
                end
            end
            S_FLUSH:
            begin
                // wait for the product register, then the accumulator
                flush_next = 1'b1;
                if (flush_reg)
                    state_next = S_EMIT;
            end
            S_EMIT:
            begin
                if (!out_valid || !out_stall)
                begin
                    load       = 1'b1;
                    state_next = S_IDLE;
                    if (last)
                    begin
                        in_col_next   = '0;
                        in_row_next   = '0;
                        in_ring_next  = '0;
                        in_done_next  = 1'b0;
                        out_col_next  = '0;
                        out_row_next  = '0;
                        out_ring_next = '0;
                    end
                    else if (EW'(out_col_reg) + EW'(1) >= w_eff)
                    begin
                        out_col_next  = '0;
                        out_row_next  = out_row_reg + ROW_W'(1);
                        out_ring_next = (32'(out_ring_reg) == LINE_ROWS - 1)
                                      ? '0 : out_ring_reg + RW'(1);
                    end
                    else
                    begin
                        out_col_next = out_col_reg + COL_W'(1);
                    end
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        // a register write restarts the frame
        if (wr_en)
        begin
            case (wr_index)
                CFG_W_C: fw_next = wr_data[9:0];
                CFG_H_C: fh_next = wr_data[12:0];
                CFG_K_C: ks_next = wr_data[3:0];
                default: ;
            endcase
            if (wr_index inside {CFG_W_C, CFG_H_C, CFG_K_C})
            begin
                in_col_next   = '0;
                in_row_next   = '0;
                in_ring_next  = '0;
                in_done_next  = 1'b0;
                out_col_next  = '0;
                out_row_next  = '0;
                out_ring_next = '0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= S_IDLE;
            fw_reg       <= 10'd300;
            fh_reg       <= 13'd300;
            ks_reg       <= 4'd15;
            in_col_reg   <= '0;
            in_row_reg   <= '0;
            in_ring_reg  <= '0;
            in_done_reg  <= 1'b0;
            out_col_reg  <= '0;
            out_row_reg  <= '0;
            out_ring_reg <= '0;
            tv_reg       <= '0;
            th_reg       <= '0;
            r_reg        <= '0;
            c_reg        <= '0;
            c0_reg       <= '0;
            ring_reg     <= '0;
            flush_reg    <= 1'b0;
            s1_valid_reg <= 1'b0;
            s1_mask_reg  <= 1'b0;
            cvalid_reg   <= '0;
        end
        else
        begin
            state_reg    <= state_next;
            fw_reg       <= fw_next;
            fh_reg       <= fh_next;
            ks_reg       <= ks_next;
            in_col_reg   <= in_col_next;
            in_row_reg   <= in_row_next;
            in_ring_reg  <= in_ring_next;
            in_done_reg  <= in_done_next;
            out_col_reg  <= out_col_next;
            out_row_reg  <= out_row_next;
            out_ring_reg <= out_ring_next;
            tv_reg       <= tv_next;
            th_reg       <= th_next;
            r_reg        <= r_next;
            c_reg        <= c_next;
            c0_reg       <= c0_next;
            ring_reg     <= ring_next;
            flush_reg    <= flush_next;
            s1_valid_reg <= issue;
            s1_mask_reg  <= issue && in_frame;
            if (cf_we)
                cvalid_reg[tv_x[TI-1:0]][th_x[TI-1:0]] <= 1'b1;
        end
    end

    // line store: one write for a new pixel, one registered read per tap
    always_ff @(posedge clk)
    begin
        if (px_we)
            line_mem[in_ring_reg][in_col_reg] <= {chan2_in, chan1_in, chan0_in};
        if (issue)
            pix_q <= line_mem[ring_reg][rd_col];
    end

    // coefficient table; unwritten entries read as zero through the valid bits
    always_ff @(posedge clk)
    begin
        if (cf_we)
            coef_mem[tv_x[TI-1:0]][th_x[TI-1:0]] <= coef_wr;
        if (issue)
        begin
            coef_q <= coef_mem[tv_reg][th_reg];
            cval_q <= cvalid_reg[tv_reg][th_reg];
        end
    end

    assign coef_use = cval_q ? coef_q : '0;

    assign lane_ctl.clear = lane_clear;
    assign lane_ctl.en    = s1_valid_reg;
    assign lane_ctl.mask  = s1_mask_reg;

    for (genvar i = 0; i < NCH; i++)
    begin : g_lane
        czp_lane #(
            .COEFF_BITS (COEFF_BITS),
            .ACC_W      (ACC_W)
        ) u_lane (
            .clk   (clk),
            .rst_n (rst_n),
            .ctl   (lane_ctl),
            .coef  (coef_use),
            .pix   (pix_q[8*i +: 8]),
            .acc   (acc[i])
        );
    end

    czp_merge #(
        .COEFF_BITS (COEFF_BITS),
        .ACC_W      (ACC_W)
    ) u_merge (
        .clk        (clk),
        .rst_n      (rst_n),
        .load       (load),
        .last       (last),
        .acc        (acc),
        .out_stall  (out_stall),
        .out_valid  (out_valid),
        .chan0_out  (chan0_out),
        .chan1_out  (chan1_out),
        .chan2_out  (chan2_out),
        .frame_last (frame_last)
    );

    assign in_stall = (state_reg != S_IDLE);

endmodule
